/* design/pesc_pkg.sv */
package pesc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_ROWS_DEF   = 64;
	localparam int ROW_OFS_BITS   = 6;

	typedef struct packed {
		logic load_in;
		logic div_init;
		logic div_step;
		logic setup;
		logic advance;
		logic emit_row;
		logic emit_err;
	} pesc_cmd_t;

	typedef struct packed {
		logic no_rows;
		logic too_tall;
		logic div_done;
		logic skip;
		logic last_row;
	} pesc_sts_t;

endpackage

/* design/pesc_if.sv */
interface pesc_edge_if #(
	parameter int COORD_BITS = pesc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic                         left_side;
	logic                         skip_first_row;

	modport source (
		output valid, start_x, start_y, end_x, end_y, left_side, skip_first_row,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, end_x, end_y, left_side, skip_first_row,
		output ready
	);
endinterface

interface pesc_span_if #(
	parameter int COORD_BITS = pesc_pkg::COORD_BITS_DEF
);
	import pesc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] span_x;
	logic [ROW_OFS_BITS-1:0]    row_offset;
	logic                       last_row;
	logic                       too_tall;

	modport source (
		output valid, span_x, row_offset, last_row, too_tall,
		input  ready
	);
	modport sink (
		input  valid, span_x, row_offset, last_row, too_tall,
		output ready
	);
endinterface

/* design/pesc_datapath.sv */
module pesc_datapath #(
	parameter int COORD_BITS = pesc_pkg::COORD_BITS_DEF,
	parameter int MAX_ROWS   = pesc_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pesc_pkg::pesc_cmd_t               cmd,
	output pesc_pkg::pesc_sts_t               sts,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	input  logic                              left_side,
	input  logic                              skip_first_row,
	output logic signed [COORD_BITS:0]        span_x,
	output logic [pesc_pkg::ROW_OFS_BITS-1:0] row_offset,
	output logic                              last_row,
	output logic                              too_tall
);
	import pesc_pkg::*;

	localparam int C         = COORD_BITS;
	localparam int X_BITS    = C + 2;
	localparam int HGT_BITS  = $clog2(MAX_ROWS + 2);
	localparam int ERR_BITS  = HGT_BITS + 1;
	localparam int CNT_BITS  = $clog2(MAX_ROWS + 1);
	localparam int IDX_BITS  = $clog2(MAX_ROWS);
	localparam int DCNT_BITS = $clog2(C);

	logic signed [C-1:0]          x1_q;
	logic signed [C:0]            dx_q;
	logic signed [C:0]            h_q;
	logic                         skip_q;
	logic                         left_q;
	logic signed [C+1:0]          rows_s;

	logic [C-1:0]                 dvd_q;
	logic [HGT_BITS-1:0]          rem_q;
	logic [DCNT_BITS-1:0]         dcnt_q;
	logic [HGT_BITS-1:0]          divisor;
	logic [ERR_BITS-1:0]          trial;
	logic                         trial_ge;

	logic signed [X_BITS-1:0]     walk_q;
	logic signed [X_BITS-1:0]     whole_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic [HGT_BITS-1:0]          rstep_q;
	logic                         sign_q;
	logic [CNT_BITS-1:0]          rows_q;
	logic [IDX_BITS-1:0]          idx_q;

	logic signed [ERR_BITS-1:0]   err_sum;
	logic                         carry;
	logic signed [X_BITS-1:0]     bump;
	logic signed [X_BITS-1:0]     walk_nx;
	logic signed [ERR_BITS-1:0]   err_nx;
	logic signed [X_BITS-1:0]     span_full;

	assign rows_s   = $signed((C+2)'(h_q) - (C+2)'({1'b0, skip_q}));
	assign divisor  = h_q[HGT_BITS-1:0];
	assign trial    = {rem_q, dvd_q[C-1]};
	assign trial_ge = trial >= {1'b0, divisor};

	assign err_sum  = $signed(err_q + $signed({1'b0, rstep_q}));
	assign carry    = err_sum > 0;
	assign bump     = !carry ? '0 : (sign_q ? '1 : X_BITS'(1));
	assign walk_nx  = walk_q + whole_q + bump;
	assign err_nx   = carry ? $signed(err_sum - $signed({1'b0, divisor})) : err_sum;
	assign span_full = left_q ? walk_q : walk_q + X_BITS'(1);

	assign sts.no_rows  = rows_s <= 0;
	assign sts.too_tall = rows_s > MAX_ROWS;
	assign sts.div_done = dcnt_q == DCNT_BITS'(C - 1);
	assign sts.skip     = skip_q;
	assign sts.last_row = rows_q == CNT_BITS'(1);

	// edge capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x1_q   <= start_x;
			dx_q   <= (C+1)'(end_x) - (C+1)'(start_x);
			h_q    <= (C+1)'(end_y) - (C+1)'(start_y);
			skip_q <= skip_first_row;
			left_q <= left_side;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_init) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q <= dx_q[C] ? C'(-dx_q) : C'(dx_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[C-2:0], trial_ge};
			rem_q <= trial_ge ? HGT_BITS'(trial - {1'b0, divisor}) : HGT_BITS'(trial);
		end
	end

	// edge walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
			idx_q  <= '0;
		end else if (cmd.setup) begin
			rows_q <= CNT_BITS'(rows_s);
			idx_q  <= '0;
		end else if (cmd.emit_row) begin
			rows_q <= rows_q - CNT_BITS'(1);
			idx_q  <= idx_q + IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			sign_q  <= dx_q[C] || (dx_q == '0);
			whole_q <= (dx_q[C] || (dx_q == '0)) ? -X_BITS'(dvd_q) : X_BITS'(dvd_q);
			rstep_q <= rem_q;
			err_q   <= dx_q[C] ? $signed(ERR_BITS'(1) - {1'b0, divisor}) : '0;
			walk_q  <= X_BITS'(x1_q);
		end else if (cmd.advance || cmd.emit_row) begin
			walk_q  <= walk_nx;
			err_q   <= err_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit_row) begin
			span_x     <= span_full[C:0];
			row_offset <= ROW_OFS_BITS'(idx_q);
			last_row   <= sts.last_row;
			too_tall   <= 1'b0;
		end else if (cmd.emit_err) begin
			span_x     <= '0;
			row_offset <= '0;
			last_row   <= 1'b1;
			too_tall   <= 1'b1;
		end
	end

endmodule

/* design/pesc_ctrl.sv */
module pesc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pesc_pkg::pesc_cmd_t cmd,
	input  pesc_pkg::pesc_sts_t sts
);
	import pesc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_SETUP = 7'b0001000,
		ST_SKIP  = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_ERR   = 7'b1000000
	} pesc_state_t;

	pesc_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        can_load;

	assign can_load  = !rsp_valid_q || rsp_ready;
	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (sts.no_rows) begin
					state_d = ST_IDLE;
				end else if (sts.too_tall) begin
					state_d = ST_ERR;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.skip ? ST_SKIP : ST_EMIT;
			end
			ST_SKIP: begin
				cmd.advance = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (can_load) begin
					cmd.emit_row = 1'b1;
					if (sts.last_row) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (can_load) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_row || cmd.emit_err) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_CHECK))
		else $error("accepted request not checked");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !(cmd.emit_row || cmd.emit_err))
		else $error("pending result overwritten");

	a_div_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_done) |=> (state_q == ST_SETUP))
		else $error("divide did not finish into setup");
`endif

endmodule

/* design/polygon_edge_scan_converter.sv */
// Walks one polygon edge per request and returns one x boundary per scan line.
// An edge is taken only while the block is idle. The check state tests the height,
// then a restoring divider produces the step and remainder one quotient bit per
// step, the setup state prepares the walk, the skip state pre-advances x when the
// top row is skipped, and then one row leaves per cycle while the output side
// takes it. An edge with no rows returns to idle with no output; an edge that is
// too tall returns a single error response with too_tall and last_row set.
// The next edge is accepted as soon as the last row sits in the output register.
module polygon_edge_scan_converter #(
	parameter int COORD_BITS = pesc_pkg::COORD_BITS_DEF,
	parameter int MAX_ROWS   = pesc_pkg::MAX_ROWS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	pesc_edge_if.sink    edge_req,
	pesc_span_if.source  span_rsp
);
	import pesc_pkg::*;

	pesc_cmd_t cmd;
	pesc_sts_t sts;

	pesc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (edge_req.valid),
		.req_ready (edge_req.ready),
		.rsp_valid (span_rsp.valid),
		.rsp_ready (span_rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pesc_datapath #(
		.COORD_BITS (COORD_BITS),
		.MAX_ROWS   (MAX_ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.start_x        (edge_req.start_x),
		.start_y        (edge_req.start_y),
		.end_x          (edge_req.end_x),
		.end_y          (edge_req.end_y),
		.left_side      (edge_req.left_side),
		.skip_first_row (edge_req.skip_first_row),
		.span_x         (span_rsp.span_x),
		.row_offset     (span_rsp.row_offset),
		.last_row       (span_rsp.last_row),
		.too_tall       (span_rsp.too_tall)
	);

endmodule

/* sim/polygon_edge_scan_converter_tb.sv */
`timescale 1ns / 100ps

module polygon_edge_scan_converter_tb;
	import pesc_pkg::*;

	localparam int CB    = COORD_BITS_DEF;
	localparam int ROWS  = MAX_ROWS_DEF;

	typedef struct {
		logic [CB-1:0] sx;
		logic [CB-1:0] sy;
		logic [CB-1:0] ex;
		logic [CB-1:0] ey;
		logic          left;
		logic          skip;
		bit            drain;
	} segment_t;

	typedef struct packed {
		logic [CB:0]             span_x;
		logic [ROW_OFS_BITS-1:0] row_offset;
		logic                    last_row;
		logic                    too_tall;
	} span_t;

	logic clk;
	logic arst_n;

	pesc_edge_if #(.COORD_BITS(CB)) edge_bus ();
	pesc_span_if #(.COORD_BITS(CB)) span_bus ();

	polygon_edge_scan_converter #(
		.COORD_BITS(CB),
		.MAX_ROWS  (ROWS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.edge_req(edge_bus.sink),
		.span_rsp(span_bus.source)
	);

	segment_t pending[$];
	span_t    span_expect[$];
	int       err_count;
	int       calm_left;
	int       gap_left;
	int       stall_left;

	// walker state
	longint trace_x;
	longint err_acc;
	longint rows_todo;
	longint step_whole;
	longint step_rem;
	longint run_height;
	bit     moving_left;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic note_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		err_count++;
	endtask

	function automatic int pick_pause();
		int r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 16);
	endfunction

	function automatic void walk_one_row();
		trace_x = trace_x + step_whole;
		err_acc = err_acc + step_rem;
		if (err_acc > 0) begin
			trace_x = moving_left ? trace_x - 1 : trace_x + 1;
			err_acc = err_acc - run_height;
		end
	endfunction

	function automatic void predict_edge_spans(segment_t s);
		longint dx;
		longint h;
		longint rows;
		longint width;
		longint v;
		int     n;
		span_t  r;
		dx = longint'($signed(s.ex)) - longint'($signed(s.sx));
		h = longint'($signed(s.ey)) - longint'($signed(s.sy));
		if (h <= 0)
			return;
		rows = h - (s.skip ? 1 : 0);
		if (rows <= 0)
			return;
		if (rows > ROWS) begin
			r.span_x = '0;
			r.row_offset = '0;
			r.last_row = 1'b1;
			r.too_tall = 1'b1;
			span_expect.push_back(r);
			return;
		end
		width = dx < 0 ? -dx : dx;
		moving_left = !(dx > 0);
		run_height = h;
		step_whole = moving_left ? -(width / h) : (width / h);
		step_rem = width % h;
		err_acc = dx >= 0 ? 0 : 1 - h;
		trace_x = longint'($signed(s.sx));
		rows_todo = rows;
		if (s.skip)
			walk_one_row();
		n = 0;
		while (rows_todo > 0) begin
			v = s.left ? trace_x : trace_x + 1;
			r.span_x = v[CB:0];
			r.row_offset = n[ROW_OFS_BITS-1:0];
			r.last_row = (rows_todo == 1);
			r.too_tall = 1'b0;
			span_expect.push_back(r);
			n++;
			rows_todo--;
			walk_one_row();
		end
	endfunction

	task automatic queue_seg(input int sx, input int sy, input int ex, input int ey,
			input bit left, input bit skip, input bit drain);
		segment_t s;
		s.sx = sx[CB-1:0];
		s.sy = sy[CB-1:0];
		s.ex = ex[CB-1:0];
		s.ey = ey[CB-1:0];
		s.left = left;
		s.skip = skip;
		s.drain = drain;
		pending.push_back(s);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		segment_t cur;
		segment_t nxt;
		if (!arst_n) begin
			edge_bus.valid <= 1'b0;
			edge_bus.start_x <= '0;
			edge_bus.start_y <= '0;
			edge_bus.end_x <= '0;
			edge_bus.end_y <= '0;
			edge_bus.left_side <= 1'b0;
			edge_bus.skip_first_row <= 1'b0;
			gap_left <= 0;
		end else begin
			if (edge_bus.valid && edge_bus.ready) begin
				cur.sx = edge_bus.start_x;
				cur.sy = edge_bus.start_y;
				cur.ex = edge_bus.end_x;
				cur.ey = edge_bus.end_y;
				cur.left = edge_bus.left_side;
				cur.skip = edge_bus.skip_first_row;
				cur.drain = 1'b0;
				predict_edge_spans(cur);
			end
			if (!edge_bus.valid || edge_bus.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					edge_bus.valid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && span_expect.size() != 0)) begin
					nxt = pending.pop_front();
					edge_bus.valid <= 1'b1;
					edge_bus.start_x <= nxt.sx;
					edge_bus.start_y <= nxt.sy;
					edge_bus.end_x <= nxt.ex;
					edge_bus.end_y <= nxt.ey;
					edge_bus.left_side <= nxt.left;
					edge_bus.skip_first_row <= nxt.skip;
					gap_left <= pick_pause();
				end else begin
					edge_bus.valid <= 1'b0;
				end
			end
		end
	end

	// span monitor
	always @(posedge clk or negedge arst_n) begin : watch_spans
		span_t got;
		span_t want;
		if (!arst_n) begin
			span_bus.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (span_bus.valid && span_bus.ready) begin
				got.span_x = span_bus.span_x;
				got.row_offset = span_bus.row_offset;
				got.last_row = span_bus.last_row;
				got.too_tall = span_bus.too_tall;
				if (span_expect.size() == 0) begin
					note_mismatch($sformatf("unexpected span x=%0d row=%0d last=%0b tall=%0b",
						$signed(got.span_x), got.row_offset, got.last_row, got.too_tall));
				end else begin
					want = span_expect.pop_front();
					if (got.span_x !== want.span_x)
						note_mismatch($sformatf("span_x got %0d want %0d",
							$signed(got.span_x), $signed(want.span_x)));
					if (got.row_offset !== want.row_offset)
						note_mismatch($sformatf("row_offset got %0d want %0d",
							got.row_offset, want.row_offset));
					if (got.last_row !== want.last_row)
						note_mismatch($sformatf("last_row got %0b want %0b",
							got.last_row, want.last_row));
					if (got.too_tall !== want.too_tall)
						note_mismatch($sformatf("too_tall got %0b want %0b",
							got.too_tall, want.too_tall));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				span_bus.ready <= 1'b0;
			end else begin
				span_bus.ready <= 1'b1;
				stall_left <= pick_pause();
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int r;
		int h;
		int sy;
		int sx;
		clk = 1'b0;
		arst_n = 1'b0;
		err_count = 0;
		calm_left = 0;
		edge_bus.valid = 1'b0;
		edge_bus.start_x = '0;
		edge_bus.start_y = '0;
		edge_bus.end_x = '0;
		edge_bus.end_y = '0;
		edge_bus.left_side = 1'b0;
		edge_bus.skip_first_row = 1'b0;
		span_bus.ready = 1'b0;

		// vertical, both sides
		queue_seg(100, 10, 100, 20, 1, 0, 0);
		queue_seg(100, 10, 100, 20, 0, 0, 0);
		// moving right and left
		queue_seg(0, 0, 37, 13, 1, 0, 0);
		queue_seg(0, 0, -37, 13, 0, 0, 0);
		queue_seg(5, 0, -20, 7, 1, 1, 0);
		// single row across the full x range
		queue_seg(-32768, -32768, 32767, -32767, 1, 0, 0);
		// skip leaves no rows
		queue_seg(0, 5, 3, 6, 1, 1, 0);
		// flat and upward edges
		queue_seg(1, 2, 3, 2, 1, 0, 0);
		queue_seg(32767, 32767, -32768, -32768, 0, 1, 0);
		// longest runs
		queue_seg(-32768, 0, 32767, 64, 0, 0, 0);
		queue_seg(32767, -100, -32768, -35, 1, 1, 0);
		// too tall
		queue_seg(0, 0, 10, 65, 1, 0, 0);
		queue_seg(-32768, -32768, 32767, 32767, 0, 0, 0);
		queue_seg(0, 0, 0, 66, 1, 1, 0);
		// x extremes
		queue_seg(32767, 0, 32767, 3, 0, 0, 0);
		queue_seg(-32768, 0, -32768, 3, 1, 0, 0);
		// slopes of exactly one, multiples, and fractions
		queue_seg(0, 0, 20, 20, 1, 0, 0);
		queue_seg(10, 0, -30, 20, 0, 1, 0);
		queue_seg(0, 0, -1, 50, 1, 0, 0);
		queue_seg(0, 0, 1, 50, 0, 1, 0);

		for (int i = 0; i < 350; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				h = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 66);
				sy = int'($urandom_range(0, 65535 - 70)) - 32768;
				sx = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(0, 1))
					queue_seg(sx, sy, sx + int'($urandom_range(0, 200)) - 100, sy + h,
						$urandom_range(0, 1), $urandom_range(0, 1), (i % 60) == 0);
				else
					queue_seg(sx, sy, int'($urandom_range(0, 65535)) - 32768, sy + h,
						$urandom_range(0, 1), $urandom_range(0, 1), (i % 60) == 0);
			end else begin
				queue_seg($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 1), $urandom_range(0, 1), (i % 60) == 0);
			end
		end

		#24 arst_n = 1'b1;

		while (pending.size() != 0 || edge_bus.valid)
			@(posedge clk);
		while (span_expect.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
